// ===== hw/rtl/audio_channel_downmix_upmix_macros.svh =====
// Assertion macros shared by the channel remix RTL.
`ifndef AUDIO_CHANNEL_DOWNMIX_UPMIX_MACROS_SVH
`define AUDIO_CHANNEL_DOWNMIX_UPMIX_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define ACDM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define ACDM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/acdm_pkg.sv =====
// Package with the mix mode codes, register indexes and control types of the remix block.
package acdm_pkg;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 3;
	localparam int NUM_CH         = 6;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_MIX_MODE      = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CHANNEL_COUNT = 2'd1;

	localparam logic [2:0] MODE_NONE         = 3'd0;
	localparam logic [2:0] MODE_MONO_STEREO  = 3'd1;
	localparam logic [2:0] MODE_STEREO_MONO  = 3'd2;
	localparam logic [2:0] MODE_STEREO_QUAD  = 3'd3;
	localparam logic [2:0] MODE_QUAD_STEREO  = 3'd4;
	localparam logic [2:0] MODE_FIVE_STEREO  = 3'd5;
	localparam logic [2:0] MODE_SIX_STEREO   = 3'd6;

	localparam logic [2:0] RESET_MIX_MODE      = MODE_NONE;
	localparam logic [2:0] RESET_CHANNEL_COUNT = 3'd2;

	// The 0.7 rear gain is 22938 / 32768.
	localparam logic [14:0] GAIN_07    = 15'd22938;
	localparam int          GAIN_SHIFT = 15;

	typedef enum logic [2:0] {
		OP_PASS,
		OP_DUP_MONO,
		OP_AVG,
		OP_DUP_STEREO,
		OP_QUAD_FOLD,
		OP_FIVE_FOLD,
		OP_SIX_FOLD
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] n_out;
	} ctrl_t;

endpackage

// ===== hw/rtl/acdm_decode.sv =====
// Mode and channel count decoder that picks the remix operation and output width.
module acdm_decode
	import acdm_pkg::*;
(
	input  logic [2:0] mix_mode,
	input  logic [2:0] channel_count,
	output ctrl_t      ctrl
);

	logic [2:0] pass_n;

	// A channel count of seven passes through as six channels.
	assign pass_n = (channel_count == 3'd7) ? 3'd6 : channel_count;

	always_comb begin
		ctrl.op    = OP_PASS;
		ctrl.n_out = pass_n;
		case (mix_mode)
			MODE_MONO_STEREO: begin
				if (channel_count == 3'd1) begin
					ctrl.op    = OP_DUP_MONO;
					ctrl.n_out = 3'd2;
				end
			end
			MODE_STEREO_MONO: begin
				if (channel_count == 3'd2) begin
					ctrl.op    = OP_AVG;
					ctrl.n_out = 3'd2;
				end
			end
			MODE_STEREO_QUAD: begin
				if (channel_count == 3'd2) begin
					ctrl.op    = OP_DUP_STEREO;
					ctrl.n_out = 3'd4;
				end
			end
			MODE_QUAD_STEREO: begin
				if (channel_count == 3'd4) begin
					ctrl.op    = OP_QUAD_FOLD;
					ctrl.n_out = 3'd4;
				end
			end
			MODE_FIVE_STEREO: begin
				if (channel_count == 3'd5) begin
					ctrl.op    = OP_FIVE_FOLD;
					ctrl.n_out = 3'd5;
				end
			end
			MODE_SIX_STEREO: begin
				if (channel_count == 3'd6) begin
					ctrl.op    = OP_SIX_FOLD;
					ctrl.n_out = 3'd6;
				end
			end
			default: begin
				ctrl.op    = OP_PASS;
				ctrl.n_out = pass_n;
			end
		endcase
	end

endmodule

// ===== hw/rtl/audio_channel_downmix_upmix.sv =====
// Top level of the audio channel remix block: three-stage up/down mix pipeline.
//
// Frames of six signed samples enter on the in channel (in_valid, in_stall)
// and leave as one remixed frame on the out channel (out_valid, out_stall),
// with out_channels giving the number of live output slots; the slots above
// it are zero. mix_mode and channel_count are written through the cfg port
// (cfg_valid, cfg_ready, cfg_index, cfg_data); the user must write them
// only while no frame is in flight, which the block does not enforce.
// cfg_ready is always high and indexes beyond the register list are ignored.
// The pipeline takes one frame per cycle while in_stall is low: stage one
// registers the samples, the decoded operation and the two rear-gain products,
// stage two registers the partial sums of the left and right mixes, stage
// three adds, saturates and forms the frame. Each stage loads whenever it is
// empty or the stage after it moves, so a stall on the out side fills the
// three stages before in_stall rises; nothing is dropped or repeated. Reset
// clears the stage valid bits, sets mix_mode to none and channel_count to two.
module audio_channel_downmix_upmix
	import acdm_pkg::*;
#(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0]        cfg_index,
	input  logic [CFG_DATA_BITS-1:0]         cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [SAMPLE_BITS-1:0]    sample_0,
	input  logic signed [SAMPLE_BITS-1:0]    sample_1,
	input  logic signed [SAMPLE_BITS-1:0]    sample_2,
	input  logic signed [SAMPLE_BITS-1:0]    sample_3,
	input  logic signed [SAMPLE_BITS-1:0]    sample_4,
	input  logic signed [SAMPLE_BITS-1:0]    sample_5,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [SAMPLE_BITS-1:0]    out_0,
	output logic signed [SAMPLE_BITS-1:0]    out_1,
	output logic signed [SAMPLE_BITS-1:0]    out_2,
	output logic signed [SAMPLE_BITS-1:0]    out_3,
	output logic signed [SAMPLE_BITS-1:0]    out_4,
	output logic signed [SAMPLE_BITS-1:0]    out_5,
	output logic [2:0]                       out_channels
);

	localparam int SB = SAMPLE_BITS;
	localparam int PW = SAMPLE_BITS + 16;
	localparam int W1 = SAMPLE_BITS + 1;
	localparam int W2 = SAMPLE_BITS + 2;
	localparam logic signed [W2-1:0] SAT_MAX = {3'b000, {(SB-1){1'b1}}};
	localparam logic signed [W2-1:0] SAT_MIN = {3'b111, {(SB-1){1'b0}}};

	typedef logic signed [SB-1:0] smp_t;

	logic [2:0] mix_mode_q;
	logic [2:0] channel_count_q;

	logic adv1, adv2, adv3;
	logic valid_s1, valid_s2, valid_s3;

	smp_t              smp_in [NUM_CH];
	ctrl_t             ctrl_in;
	smp_t              smp_s1 [NUM_CH];
	ctrl_t             ctrl_s1;
	logic signed [PW-1:0] prod2_s1, prod3_s1;
	smp_t              smp_s2 [NUM_CH];
	ctrl_t             ctrl_s2;
	logic signed [W1-1:0] pl_s2, ql_s2, pr_s2, qr_s2;
	smp_t              out_s3 [NUM_CH];
	logic [2:0]        n_s3;

	smp_t a0, a1, a2, a3, b0, b1, b2, b3;
	smp_t g2, g3;
	logic signed [W2-1:0] sum_l, sum_r;
	smp_t mix_l, mix_r;
	smp_t out_nxt [NUM_CH];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_mode_q      <= RESET_MIX_MODE;
			channel_count_q <= RESET_CHANNEL_COUNT;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_MIX_MODE) begin
				mix_mode_q <= cfg_data;
			end else if (cfg_index == CFG_CHANNEL_COUNT) begin
				channel_count_q <= cfg_data;
			end
		end
	end

	assign adv3     = !valid_s3 || !out_stall;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= in_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	assign smp_in[0] = sample_0;
	assign smp_in[1] = sample_1;
	assign smp_in[2] = sample_2;
	assign smp_in[3] = sample_3;
	assign smp_in[4] = sample_4;
	assign smp_in[5] = sample_5;

	acdm_decode u_decode (
		.mix_mode      (mix_mode_q),
		.channel_count (channel_count_q),
		.ctrl          (ctrl_in)
	);

	// Stage one: samples, operation and the rear-gain products.
	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			smp_s1   <= smp_in;
			ctrl_s1  <= ctrl_in;
			prod2_s1 <= PW'(sample_2) * PW'(signed'({1'b0, GAIN_07}));
			prod3_s1 <= PW'(sample_3) * PW'(signed'({1'b0, GAIN_07}));
		end
	end

	assign g2 = SB'(prod2_s1 >>> GAIN_SHIFT);
	assign g3 = SB'(prod3_s1 >>> GAIN_SHIFT);

	always_comb begin
		a0 = smp_s1[0];
		b0 = smp_s1[1];
		a1 = '0;
		a2 = '0;
		a3 = '0;
		b1 = '0;
		b2 = '0;
		b3 = '0;
		case (ctrl_s1.op)
			OP_AVG: begin
				a1 = smp_s1[1];
			end
			OP_QUAD_FOLD: begin
				a1 = g2;
				b1 = g3;
			end
			OP_FIVE_FOLD: begin
				a1 = smp_s1[2] >>> 1;
				a2 = smp_s1[3] >>> 1;
				b1 = smp_s1[2] >>> 1;
				b2 = smp_s1[4] >>> 1;
			end
			OP_SIX_FOLD: begin
				a1 = smp_s1[2] >>> 1;
				a2 = smp_s1[3] >>> 1;
				a3 = smp_s1[4] >>> 1;
				b1 = smp_s1[2] >>> 1;
				b2 = smp_s1[3] >>> 1;
				b3 = smp_s1[5] >>> 1;
			end
			default: begin
				a1 = '0;
			end
		endcase
	end

	// Stage two: pairwise partial sums of the left and right mixes.
	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			smp_s2  <= smp_s1;
			ctrl_s2 <= ctrl_s1;
			pl_s2   <= W1'(a0) + W1'(a1);
			ql_s2   <= W1'(a2) + W1'(a3);
			pr_s2   <= W1'(b0) + W1'(b1);
			qr_s2   <= W1'(b2) + W1'(b3);
		end
	end

	always_comb begin
		sum_l = W2'(pl_s2) + W2'(ql_s2);
		sum_r = W2'(pr_s2) + W2'(qr_s2);
		if (ctrl_s2.op == OP_AVG) begin
			sum_l = sum_l >>> 1;
		end
		if (sum_l > SAT_MAX) begin
			mix_l = SB'(SAT_MAX);
		end else if (sum_l < SAT_MIN) begin
			mix_l = SB'(SAT_MIN);
		end else begin
			mix_l = SB'(sum_l);
		end
		if (sum_r > SAT_MAX) begin
			mix_r = SB'(SAT_MAX);
		end else if (sum_r < SAT_MIN) begin
			mix_r = SB'(SAT_MIN);
		end else begin
			mix_r = SB'(sum_r);
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			out_nxt[i] = '0;
		end
		case (ctrl_s2.op)
			OP_DUP_MONO: begin
				out_nxt[0] = smp_s2[0];
				out_nxt[1] = smp_s2[0];
			end
			OP_AVG: begin
				out_nxt[0] = mix_l;
				out_nxt[1] = mix_l;
			end
			OP_DUP_STEREO: begin
				out_nxt[0] = smp_s2[0];
				out_nxt[1] = smp_s2[1];
				out_nxt[2] = smp_s2[0];
				out_nxt[3] = smp_s2[1];
			end
			OP_QUAD_FOLD: begin
				out_nxt[0] = mix_l;
				out_nxt[1] = mix_r;
				out_nxt[2] = mix_l;
				out_nxt[3] = mix_r;
			end
			OP_FIVE_FOLD: begin
				out_nxt[0] = mix_l;
				out_nxt[1] = mix_r;
				out_nxt[2] = smp_s2[2] >>> 1;
				out_nxt[3] = mix_l;
				out_nxt[4] = mix_r;
			end
			OP_SIX_FOLD: begin
				out_nxt[0] = mix_l;
				out_nxt[1] = mix_r;
				out_nxt[2] = smp_s2[2] >>> 1;
				out_nxt[3] = smp_s2[3] >>> 1;
				out_nxt[4] = mix_l;
				out_nxt[5] = mix_r;
			end
			default: begin
				for (int i = 0; i < NUM_CH; i++) begin
					if (3'(i) < ctrl_s2.n_out) begin
						out_nxt[i] = smp_s2[i];
					end
				end
			end
		endcase
	end

	// Stage three: the finished frame, held while the receiver stalls.
	always_ff @(posedge clk) begin
		if (adv3 && valid_s2) begin
			out_s3 <= out_nxt;
			n_s3   <= ctrl_s2.n_out;
		end
	end

	assign out_valid    = valid_s3;
	assign out_0        = out_s3[0];
	assign out_1        = out_s3[1];
	assign out_2        = out_s3[2];
	assign out_3        = out_s3[3];
	assign out_4        = out_s3[4];
	assign out_5        = out_s3[5];
	assign out_channels = n_s3;

`include "audio_channel_downmix_upmix_macros.svh"

	`ACDM_ASSERT_NOW(a_full_stall, valid_s1 && valid_s2 && valid_s3 && out_stall, in_stall, "full pipeline under stall must stall the input")
	`ACDM_ASSERT_NEXT(a_accept_fills, in_valid && !in_stall, valid_s1, "accepted request did not enter stage one")
	`ACDM_ASSERT_NOW(a_count_range, out_valid, out_channels <= 3'd6, "output channel count above six")
	`ACDM_ASSERT_NOW(a_top_slot_zero, out_valid && out_channels < 3'd6, out_5 == '0, "unused top output slot is not zero")

endmodule
